FILE: hw/rtl/dlle_pkg.sv
// Package: shared types, constants and codes of the linked list engine.
package dlle_pkg;
  localparam int POOL_NODES_DEF = 64;
  localparam int IDX_W = 7;
  localparam logic [IDX_W-1:0] NIL = 7'd127;

  typedef enum logic [2:0] {
    OP_INS_HEAD = 3'd0, OP_INS_TAIL = 3'd1, OP_INS_POS = 3'd2, OP_DEL_HEAD = 3'd3,
    OP_DEL_TAIL = 3'd4, OP_DEL_AFTER = 3'd5, OP_SEARCH = 3'd6, OP_DUMP = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_OVERFLOW = 3'd1, ST_UNDERFLOW = 3'd2, ST_BAD_POS = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] element;
    logic        element_valid;
    logic [6:0]  found_position;
    logic [6:0]  node_count;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] value;
    logic [6:0]  position;
  } item_t;
endpackage

FILE: hw/rtl/dlle_if.sv
// Interfaces: valid/ready channels for input items and result items.
interface dlle_in_if;
  logic           valid;
  logic           ready;
  dlle_pkg::item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface dlle_out_if;
  logic             valid;
  logic             ready;
  dlle_pkg::result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/dlle_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module dlle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/doubly_linked_list_engine.sv
// Top level: doubly linked list engine over a pooled node memory.
//
//  channel | dir | handshake     | payload
//  in      | in  | valid/ready   | opcode, value, position
//  out     | out | valid/ready   | status, element, element_valid, found_position,
//          |     |               | node_count, last
//
// One item at a time. Head/tail inserts and deletes do not walk the list;
// positional insert, search, delete-after and dump walk it node by node (issue
// the read, then use the data). Dump emits one transfer per element; the walk
// holds while the output register is full. Reset clears head, tail, counters and
// the sequencer; memories are not cleared. in_ready is high only while no item
// is in flight.
module doubly_linked_list_engine #(
  parameter int POOL_NODES = dlle_pkg::POOL_NODES_DEF
) (
  input logic clk,
  input logic rst_n,
  dlle_in_if.sink    in_ch,
  dlle_out_if.source out_ch
);
  localparam int AW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int IW = dlle_pkg::IDX_W;
  localparam logic [IW-1:0] NODES = IW'(POOL_NODES);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DISP  = 10'b0000000010,
    S_WALK  = 10'b0000000100,
    S_WWAIT = 10'b0000001000,
    S_POPW  = 10'b0000010000,
    S_LINK  = 10'b0000100000,
    S_UNRD  = 10'b0001000000,
    S_UNW   = 10'b0010000000,
    S_UNLK  = 10'b0100000000,
    S_EMIT  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  dlle_pkg::item_t item_r, item_nxt;
  logic [IW-1:0] head_r, head_nxt, tail_r, tail_nxt, top_r, top_nxt;
  logic [IW-1:0] fresh_r, fresh_nxt, count_r, count_nxt;
  logic [IW-1:0] cur_r, cur_nxt, pos_r, pos_nxt, node_r, node_nxt, succ_r, succ_nxt;
  logic [IW-1:0] pred_r, pred_nxt;
  logic [1:0]    lstep_r, lstep_nxt;
  logic          ovalid_r, ovalid_nxt;
  dlle_pkg::result_t ores_r, ores_nxt;

  // memories: value, next, prev, free stack
  logic          v_we, n_we, p_we, f_we;
  logic [AW-1:0] v_wa, n_wa, p_wa, f_wa, v_ra, n_ra, p_ra, f_ra;
  logic [31:0]   v_wd, v_rd;
  logic [IW-1:0] n_wd, n_rd, p_wd, p_rd;
  logic [AW-1:0] f_wd, f_rd;

  dlle_ram #(.WIDTH(32), .DEPTH(POOL_NODES)) u_val (.clk, .we(v_we), .waddr(v_wa),
    .wdata(v_wd), .raddr(v_ra), .rdata(v_rd));
  dlle_ram #(.WIDTH(IW), .DEPTH(POOL_NODES)) u_next (.clk, .we(n_we), .waddr(n_wa),
    .wdata(n_wd), .raddr(n_ra), .rdata(n_rd));
  dlle_ram #(.WIDTH(IW), .DEPTH(POOL_NODES)) u_prev (.clk, .we(p_we), .waddr(p_wa),
    .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));
  dlle_ram #(.WIDTH(AW), .DEPTH(POOL_NODES)) u_free (.clk, .we(f_we), .waddr(f_wa),
    .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));

  function automatic logic is_node(input logic [IW-1:0] i);
    return i < NODES;
  endfunction

  function automatic dlle_pkg::result_t res(input dlle_pkg::status_t s,
                                            input logic [IW-1:0] fp,
                                            input logic [IW-1:0] cnt);
    dlle_pkg::result_t r;
    r = '0;
    r.status = s;
    r.found_position = fp;
    r.node_count = cnt;
    r.last = 1'b1;
    return r;
  endfunction

  logic in_xfer, out_xfer, out_free;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = ovalid_r;
  assign out_ch.payload = ores_r;
  assign out_xfer     = ovalid_r && out_ch.ready;
  assign out_free     = !ovalid_r || out_ch.ready;

  always_comb begin
    logic found;
    state_nxt = state_r; item_nxt = item_r;
    head_nxt = head_r; tail_nxt = tail_r; top_nxt = top_r; fresh_nxt = fresh_r;
    count_nxt = count_r; cur_nxt = cur_r; pos_nxt = pos_r; node_nxt = node_r;
    succ_nxt = succ_r; pred_nxt = pred_r; lstep_nxt = lstep_r;
    ovalid_nxt = out_xfer ? 1'b0 : ovalid_r;
    ores_nxt = ores_r;
    v_we = 1'b0; n_we = 1'b0; p_we = 1'b0; f_we = 1'b0;
    v_wa = '0; n_wa = '0; p_wa = '0; f_wa = '0;
    v_wd = item_r.value; n_wd = '0; p_wd = '0; f_wd = '0;
    v_ra = cur_r[AW-1:0]; n_ra = cur_r[AW-1:0]; p_ra = succ_r[AW-1:0];
    f_ra = AW'(top_r - 1'b1);
    found = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          item_nxt = in_ch.payload;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        // dispatch once the output register is free, so a result always fits;
        // read prev of the head so a direct insert sees its predecessor
        p_ra = head_r[AW-1:0];
        if (out_free) begin
          cur_nxt = head_r; pos_nxt = 7'd1;
          case (item_r.opcode)
            dlle_pkg::OP_INS_HEAD, dlle_pkg::OP_INS_TAIL, dlle_pkg::OP_INS_POS: begin
              if (top_r == '0 && fresh_r >= NODES) begin
                ovalid_nxt = 1'b1;
                ores_nxt = res(dlle_pkg::ST_OVERFLOW, '0, count_r);
                state_nxt = S_IDLE;
              end else if (item_r.opcode == dlle_pkg::OP_INS_POS &&
                           (item_r.position == '0 || item_r.position > count_r + 1'b1)) begin
                ovalid_nxt = 1'b1;
                ores_nxt = res(dlle_pkg::ST_BAD_POS, '0, count_r);
                state_nxt = S_IDLE;
              end else begin
                succ_nxt = (item_r.opcode == dlle_pkg::OP_INS_TAIL) ? dlle_pkg::NIL : head_r;
                state_nxt = (item_r.opcode == dlle_pkg::OP_INS_POS &&
                             item_r.position != 7'd1) ? S_WALK : S_POPW;
              end
            end
            dlle_pkg::OP_DEL_HEAD, dlle_pkg::OP_DEL_TAIL: begin
              if (count_r == '0) begin
                ovalid_nxt = 1'b1;
                ores_nxt = res(dlle_pkg::ST_UNDERFLOW, '0, count_r);
                state_nxt = S_IDLE;
              end else begin
                node_nxt = (item_r.opcode == dlle_pkg::OP_DEL_HEAD) ? head_r : tail_r;
                state_nxt = S_UNRD;
              end
            end
            default: begin
              if (count_r == '0) begin
                ovalid_nxt = 1'b1;
                ores_nxt = res((item_r.opcode == dlle_pkg::OP_DUMP) ? dlle_pkg::ST_OK
                               : dlle_pkg::ST_NOT_FOUND, '0, count_r);
                state_nxt = S_IDLE;
              end else state_nxt = S_WALK;
            end
          endcase
        end
      end
      S_WALK: begin
        // issue reads of cur; data returns next cycle
        state_nxt = S_WWAIT;
      end
      S_WWAIT: begin
        case (item_r.opcode)
          dlle_pkg::OP_INS_POS: begin
            // read prev of the new successor for the link step
            p_ra = n_rd[AW-1:0];
            cur_nxt = n_rd; succ_nxt = n_rd; pos_nxt = pos_r + 1'b1;
            state_nxt = (pos_r + 1'b1 == item_r.position) ? S_POPW : S_WALK;
          end
          dlle_pkg::OP_DUMP: begin
            if (out_free) begin
              ovalid_nxt = 1'b1;
              ores_nxt = '0;
              ores_nxt.element = v_rd;
              ores_nxt.element_valid = 1'b1;
              ores_nxt.node_count = count_r;
              ores_nxt.last = (pos_r == count_r) || !is_node(n_rd);
              cur_nxt = n_rd; pos_nxt = pos_r + 1'b1;
              state_nxt = ores_nxt.last ? S_IDLE : S_WALK;
            end
          end
          default: begin
            found = (v_rd == item_r.value);
            if (found) begin
              if (item_r.opcode == dlle_pkg::OP_SEARCH) begin
                ovalid_nxt = 1'b1;
                ores_nxt = res(dlle_pkg::ST_OK, pos_r, count_r);
                state_nxt = S_IDLE;
              end else if (!is_node(n_rd)) begin
                ovalid_nxt = 1'b1;
                ores_nxt = res(dlle_pkg::ST_NOT_FOUND, '0, count_r);
                state_nxt = S_IDLE;
              end else begin
                node_nxt = n_rd;
                state_nxt = S_UNRD;
              end
            end else if (pos_r == count_r || !is_node(n_rd)) begin
              ovalid_nxt = 1'b1;
              ores_nxt = res(dlle_pkg::ST_NOT_FOUND, '0, count_r);
              state_nxt = S_IDLE;
            end else begin
              cur_nxt = n_rd; pos_nxt = pos_r + 1'b1;
              state_nxt = S_WALK;
            end
          end
        endcase
      end
      S_POPW: begin
        // free stack read (issued in the prior cycle) and prev[succ] read done;
        // pick the node: popped entry or a fresh one
        if (top_r != '0) begin
          node_nxt = IW'(f_rd);
          top_nxt = top_r - 1'b1;
        end else begin
          node_nxt = fresh_r;
          fresh_nxt = fresh_r + 1'b1;
        end
        pred_nxt = is_node(succ_r) ? p_rd : tail_r;
        lstep_nxt = 2'd0;
        state_nxt = S_LINK;
      end
      S_LINK: begin
        // one write per link memory per cycle, two steps
        if (lstep_r == 2'd0) begin
          v_we = 1'b1; v_wa = node_r[AW-1:0];
          n_we = 1'b1; n_wa = node_r[AW-1:0]; n_wd = succ_r;
          p_we = 1'b1; p_wa = node_r[AW-1:0]; p_wd = pred_r;
          lstep_nxt = 2'd1;
        end else begin
          if (is_node(pred_r)) begin
            n_we = 1'b1; n_wa = pred_r[AW-1:0]; n_wd = node_r;
          end else head_nxt = node_r;
          if (is_node(succ_r)) begin
            p_we = 1'b1; p_wa = succ_r[AW-1:0]; p_wd = node_r;
          end else tail_nxt = node_r;
          count_nxt = count_r + 1'b1;
          ovalid_nxt = 1'b1;
          ores_nxt = res(dlle_pkg::ST_OK, '0, count_r + 1'b1);
          state_nxt = S_IDLE;
        end
      end
      S_UNRD: begin
        n_ra = node_r[AW-1:0]; p_ra = node_r[AW-1:0];
        state_nxt = S_UNW;
      end
      S_UNW: begin
        pred_nxt = p_rd; succ_nxt = n_rd;
        state_nxt = S_UNLK;
      end
      S_UNLK: begin
        if (is_node(pred_r)) begin
          n_we = 1'b1; n_wa = pred_r[AW-1:0]; n_wd = succ_r;
        end else head_nxt = succ_r;
        if (is_node(succ_r)) begin
          p_we = 1'b1; p_wa = succ_r[AW-1:0]; p_wd = pred_r;
        end else tail_nxt = pred_r;
        if (count_r != '0) count_nxt = count_r - 1'b1;
        if (top_r < NODES) begin
          f_we = 1'b1; f_wa = top_r[AW-1:0]; f_wd = node_r[AW-1:0];
          top_nxt = top_r + 1'b1;
        end
        ovalid_nxt = 1'b1;
        ores_nxt = res(dlle_pkg::ST_OK, '0, (count_r != '0) ? count_r - 1'b1 : count_r);
        state_nxt = S_IDLE;
      end
      S_EMIT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r <= dlle_pkg::NIL; tail_r <= dlle_pkg::NIL;
      top_r <= '0; fresh_r <= '0; count_r <= '0; ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r <= head_nxt; tail_r <= tail_nxt;
      top_r <= top_nxt; fresh_r <= fresh_nxt; count_r <= count_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt; cur_r <= cur_nxt; pos_r <= pos_nxt; node_r <= node_nxt;
    succ_r <= succ_nxt; pred_r <= pred_nxt; lstep_r <= lstep_nxt; ores_r <= ores_nxt;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NODES) else $error("list count above pool size");
  a_empty_nil: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && count_r == '0) |-> (head_r == dlle_pkg::NIL &&
    tail_r == dlle_pkg::NIL)) else $error("empty list with live head or tail");
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !out_ch.ready) |=> (ovalid_r && $stable(ores_r)))
    else $error("stalled result changed");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ch.ready) else $error("accepted while busy");
`endif
endmodule

FILE: tb/tb_doubly_linked_list_engine.sv
// Testbench: random and directed list operations checked against a queue-based list predictor.
module tb_doubly_linked_list_engine;

  localparam int NODES      = dlle_pkg::POOL_NODES_DEF;
  localparam int RAND_ITEMS = 345;
  localparam int QUIET_FROM = 305;   // no idling on either side past this item
  localparam int STALL_LIMIT = 3000; // cycles without any transfer before giving up

  // Scoreboard: holds the predicted list contents and the results still owed.
  class list_scoreboard;
    logic signed [31:0] contents[$];
    dlle_pkg::result_t owed[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function int list_len();
      return contents.size();
    endfunction

    function void push_result(dlle_pkg::status_t st, logic [31:0] el, logic ev,
                              logic [6:0] fp, logic lst);
      dlle_pkg::result_t r;
      r.status = st;
      r.element = el;
      r.element_valid = ev;
      r.found_position = fp;
      r.node_count = 7'(contents.size());
      r.last = lst;
      owed.push_back(r);
    endfunction

    // Predict the results of one accepted item and advance the list.
    function void note_item(dlle_pkg::item_t it);
      int hit;
      int len;
      dlle_pkg::op_t op;
      len = contents.size();
      hit = -1;
      op = dlle_pkg::op_t'(it.opcode);
      case (op)
        dlle_pkg::OP_INS_HEAD, dlle_pkg::OP_INS_TAIL, dlle_pkg::OP_INS_POS: begin
          // A full pool wins over a bad position.
          if (len >= NODES) push_result(dlle_pkg::ST_OVERFLOW, 0, 0, 0, 1);
          else if (op == dlle_pkg::OP_INS_HEAD) begin
            contents.push_front(it.value);
            push_result(dlle_pkg::ST_OK, 0, 0, 0, 1);
          end else if (op == dlle_pkg::OP_INS_TAIL) begin
            contents.push_back(it.value);
            push_result(dlle_pkg::ST_OK, 0, 0, 0, 1);
          end else if (it.position == 0 || int'(it.position) > len + 1) begin
            push_result(dlle_pkg::ST_BAD_POS, 0, 0, 0, 1);
          end else begin
            contents.insert(int'(it.position) - 1, it.value);
            push_result(dlle_pkg::ST_OK, 0, 0, 0, 1);
          end
        end
        dlle_pkg::OP_DEL_HEAD, dlle_pkg::OP_DEL_TAIL: begin
          if (len == 0) push_result(dlle_pkg::ST_UNDERFLOW, 0, 0, 0, 1);
          else begin
            if (op == dlle_pkg::OP_DEL_HEAD) void'(contents.pop_front());
            else void'(contents.pop_back());
            push_result(dlle_pkg::ST_OK, 0, 0, 0, 1);
          end
        end
        dlle_pkg::OP_DEL_AFTER, dlle_pkg::OP_SEARCH: begin
          for (int i = 0; i < len; i++) begin
            if (contents[i] == it.value) begin
              hit = i;
              break;
            end
          end
          if (hit < 0) push_result(dlle_pkg::ST_NOT_FOUND, 0, 0, 0, 1);
          else if (op == dlle_pkg::OP_SEARCH)
            push_result(dlle_pkg::ST_OK, 0, 0, 7'(hit + 1), 1);
          else if (hit == len - 1) push_result(dlle_pkg::ST_NOT_FOUND, 0, 0, 0, 1);
          else begin
            contents.delete(hit + 1);
            push_result(dlle_pkg::ST_OK, 0, 0, 0, 1);
          end
        end
        default: begin
          if (len == 0) push_result(dlle_pkg::ST_OK, 0, 0, 0, 1);
          else for (int i = 0; i < len; i++)
            push_result(dlle_pkg::ST_OK, contents[i], 1, 0, i == len - 1);
        end
      endcase
    endfunction

    // Compare one result transfer with the oldest owed result.
    function void check_result(dlle_pkg::result_t got);
      dlle_pkg::result_t exp_r;
      if (owed.size() == 0) begin
        $error("unexpected result transfer: %p", got);
        errors++;
        return;
      end
      exp_r = owed.pop_front();
      if (got.status !== exp_r.status) begin
        $error("status: expected %0d, actual %0d", exp_r.status, got.status);
        errors++;
      end
      if (got.element !== exp_r.element) begin
        $error("element: expected %0d, actual %0d", $signed(exp_r.element),
               $signed(got.element));
        errors++;
      end
      if (got.element_valid !== exp_r.element_valid) begin
        $error("element_valid: expected %0d, actual %0d", exp_r.element_valid,
               got.element_valid);
        errors++;
      end
      if (got.found_position !== exp_r.found_position) begin
        $error("found_position: expected %0d, actual %0d", exp_r.found_position,
               got.found_position);
        errors++;
      end
      if (got.node_count !== exp_r.node_count) begin
        $error("node_count: expected %0d, actual %0d", exp_r.node_count, got.node_count);
        errors++;
      end
      if (got.last !== exp_r.last) begin
        $error("last: expected %0d, actual %0d", exp_r.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic quiet;     // set for the tail of the run: no idling on either side
  int   idle_cnt;  // cycles since the last transfer on either channel

  dlle_in_if  in_ch();
  dlle_out_if out_ch();

  list_scoreboard sb;

  doubly_linked_list_engine i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Drive out_ch.ready: stall in random bursts, never once quiet.
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (quiet) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Check every result transfer; values seen here are the ones before this edge.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.payload);
  end

  // Watchdog: count cycles without any transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Present one item and hold it until the transfer; valid stays high afterward.
  task automatic send_item(dlle_pkg::op_t op, logic [31:0] val, logic [6:0] pos);
    dlle_pkg::item_t it;
    it.opcode = op;
    it.value = val;
    it.position = pos;
    in_ch.valid <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(it);
  endtask

  // Drop valid for a random burst, or not at all.
  task automatic maybe_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Values drawn mostly from a small set so searches and delete-after hit often.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      default: return 32'($urandom_range(0, 11));
    endcase
  endfunction

  function automatic logic [6:0] pick_position(int len);
    if ($urandom_range(0, 4) == 0) return 7'($urandom_range(0, 127));
    return 7'($urandom_range(1, len + 1));
  endfunction

  initial begin
    int roll;
    int fill;
    dlle_pkg::op_t op;
    sb = new();
    quiet = 1'b0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.payload <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-list cases first, then the extremes and every operation.
    send_item(dlle_pkg::OP_DUMP, 0, 0);
    send_item(dlle_pkg::OP_DEL_HEAD, 0, 0);
    send_item(dlle_pkg::OP_DEL_TAIL, 0, 0);
    send_item(dlle_pkg::OP_SEARCH, 5, 0);
    send_item(dlle_pkg::OP_DEL_AFTER, 5, 0);
    send_item(dlle_pkg::OP_INS_POS, 1, 0);
    send_item(dlle_pkg::OP_INS_POS, 1, 2);
    send_item(dlle_pkg::OP_INS_POS, 32'h7fff_ffff, 1);
    send_item(dlle_pkg::OP_INS_HEAD, 32'h8000_0000, 127);
    send_item(dlle_pkg::OP_INS_TAIL, 32'hffff_ffff, 0);
    send_item(dlle_pkg::OP_INS_POS, 7, 4);
    send_item(dlle_pkg::OP_INS_POS, 9, 2);
    send_item(dlle_pkg::OP_INS_POS, 3, 7'h7f);
    send_item(dlle_pkg::OP_DUMP, 0, 0);
    send_item(dlle_pkg::OP_SEARCH, 7, 0);
    send_item(dlle_pkg::OP_SEARCH, 32'h8000_0000, 0);
    send_item(dlle_pkg::OP_SEARCH, 1234, 0);
    send_item(dlle_pkg::OP_DEL_AFTER, 7, 0);
    send_item(dlle_pkg::OP_DEL_AFTER, 32'h8000_0000, 0);
    send_item(dlle_pkg::OP_DEL_AFTER, 4321, 0);
    send_item(dlle_pkg::OP_DEL_HEAD, 0, 0);
    send_item(dlle_pkg::OP_DEL_TAIL, 0, 0);
    send_item(dlle_pkg::OP_DUMP, 0, 0);
    send_item(dlle_pkg::OP_DEL_HEAD, 0, 0);
    send_item(dlle_pkg::OP_DEL_HEAD, 0, 0);

    // Random: alternate fill and drain phases so the pool runs full and empty.
    fill = 1;
    for (int k = 0; k < RAND_ITEMS; k++) begin
      if (k >= QUIET_FROM) quiet = 1'b1;
      if (sb.list_len() >= NODES && $urandom_range(0, 3) == 0) fill = 0;
      if (sb.list_len() == 0 && $urandom_range(0, 1) == 0) fill = 1;
      roll = $urandom_range(0, 99);
      if (roll < 4) op = dlle_pkg::OP_DUMP;
      else if (roll < 16)
        op = ($urandom_range(0, 1) != 0) ? dlle_pkg::OP_SEARCH : dlle_pkg::OP_DEL_AFTER;
      else if ((roll < 88) == (fill == 1))
        op = dlle_pkg::op_t'($urandom_range(dlle_pkg::OP_INS_HEAD, dlle_pkg::OP_INS_POS));
      else
        op = ($urandom_range(0, 1) != 0) ? dlle_pkg::OP_DEL_HEAD : dlle_pkg::OP_DEL_TAIL;
      send_item(op, pick_value(), pick_position(sb.list_len()));
      maybe_gap();
    end
    in_ch.valid <= 1'b0;

    // Drain: wait for every owed result, then let the block settle.
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
